/* design/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");
// next-cycle implication
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons)
`define ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif

`endif

/* design/hduart_pkg.sv */
package hduart_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int SPAN         = 2 * BUFFER_DEPTH;
	localparam int PTR_W        = $clog2(SPAN);
	localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
	localparam int AVAIL_W      = 5;
	localparam int PERIOD_W     = 16;
	localparam int CNT_W        = 4;

	localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST   = 16'd416;
	localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 16'd624;

	// bit counter values inside a frame
	localparam logic [CNT_W-1:0] TX_START_CNT = 4'd0;
	localparam logic [CNT_W-1:0] TX_STOP_CNT  = 4'd9;
	localparam logic [CNT_W-1:0] RX_FIRST_CNT = 4'd0;
	localparam logic [CNT_W-1:0] RX_LAST_CNT  = 4'd7;

	typedef enum logic [0:0] {
		REG_BIT_PERIOD   = 1'b0,
		REG_START_PERIOD = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TX   = 3'b010,
		ST_RX   = 3'b100
	} state_t;

	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
	} push_t;

	typedef struct packed {
		logic  tx_level;
		logic  accepted;
		logic  busy;
		push_t store;
	} frame_res_t;

	typedef struct packed {
		logic [7:0]         read_byte;
		logic               read_valid;
		logic [AVAIL_W-1:0] avail;
		logic               dropped;
	} buf_res_t;

	typedef struct packed {
		logic               tx_level;
		logic               send_accepted;
		logic [7:0]         read_byte;
		logic               read_valid;
		logic [AVAIL_W-1:0] bytes_available;
		logic               busy_res;
		logic               rx_dropped;
	} res_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(SPAN - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p >= PTR_W'(BUFFER_DEPTH)) r = p - PTR_W'(BUFFER_DEPTH);
		else r = p;
		return r[SLOT_W-1:0];
	endfunction

endpackage

/* design/hduart_frame.sv */
module hduart_frame (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              rx_level,
	input  logic                              send_req,
	input  logic [7:0]                        send_byte,
	input  logic [hduart_pkg::PERIOD_W-1:0]   bit_period,
	input  logic [hduart_pkg::PERIOD_W-1:0]   start_period,
	output hduart_pkg::frame_res_t            fres
);
	import hduart_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [PERIOD_W-1:0] timer_q, timer_d;
	logic [PERIOD_W-1:0] cmp_q, cmp_d;
	logic [7:0]          shift_q, shift_d;
	logic                line_q, line_d;
	logic                prev_q, prev_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		timer_d = timer_q;
		cmp_d   = cmp_q;
		shift_d = shift_q;
		line_d  = line_q;
		prev_d  = prev_q;
		fres    = '0;
		if (en) begin
			unique case (state_q)
				ST_IDLE: begin
					if (send_req) begin
						shift_d       = send_byte;
						state_d       = ST_TX;
						cnt_d         = TX_START_CNT;
						cmp_d         = bit_period;
						timer_d       = '0;
						fres.accepted = 1'b1;
					end else if (prev_q && !rx_level) begin
						state_d = ST_RX;
						cnt_d   = RX_FIRST_CNT;
						cmp_d   = start_period;
						timer_d = '0;
					end
				end
				ST_TX: begin
					if (timer_q == cmp_q) begin
						timer_d = '0;
						priority if (cnt_q == TX_START_CNT) begin
							line_d = 1'b0;
							cnt_d  = cnt_q + 1'b1;
						end else if (cnt_q == TX_STOP_CNT) begin
							line_d  = 1'b1;
							state_d = ST_IDLE;
						end else begin
							line_d  = shift_q[0];
							shift_d = {1'b0, shift_q[7:1]};
							cnt_d   = cnt_q + 1'b1;
						end
					end else begin
						timer_d = timer_q + 1'b1;
					end
				end
				ST_RX: begin
					if (timer_q == cmp_q) begin
						timer_d = '0;
						if (cnt_q == RX_FIRST_CNT) cmp_d = bit_period;
						shift_d = {rx_level, shift_q[7:1]};
						if (cnt_q == RX_LAST_CNT) begin
							fres.store.push      = 1'b1;
							fres.store.push_byte = shift_d;
							state_d              = ST_IDLE;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end else begin
						timer_d = timer_q + 1'b1;
					end
				end
				default: state_d = ST_IDLE;
			endcase
			prev_d = rx_level;
		end
		fres.tx_level = line_d;
		fres.busy     = (state_d != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			timer_q <= '0;
			cmp_q   <= BIT_PERIOD_RST;
			shift_q <= '0;
			line_q  <= 1'b1;
			prev_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			timer_q <= timer_d;
			cmp_q   <= cmp_d;
			shift_q <= shift_d;
			line_q  <= line_d;
			prev_q  <= prev_d;
		end
	end

endmodule

/* design/hduart_rxbuf.sv */
module hduart_rxbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   read_req,
	input  hduart_pkg::push_t      store,
	output hduart_pkg::buf_res_t   bres
);
	import hduart_pkg::*;

	logic [7:0]       store_q [BUFFER_DEPTH];
	logic [PTR_W-1:0] wr_q, wr_d;
	logic [PTR_W-1:0] rd_q, rd_d;
	logic [PTR_W-1:0] fill, fill_mid, fill_end;
	logic             do_write;

	always_comb begin
		wr_d     = wr_q;
		rd_d     = rd_q;
		do_write = 1'b0;
		bres     = '0;
		if (wr_q >= rd_q) fill = wr_q - rd_q;
		else fill = wr_q + PTR_W'(SPAN) - rd_q;
		fill_mid = fill;
		// serve the read first so it frees a slot for this tick's store
		if (en && read_req && (fill != '0)) begin
			bres.read_byte  = store_q[slot_of(rd_q)];
			bres.read_valid = 1'b1;
			rd_d            = next_ptr(rd_q);
			fill_mid        = fill - 1'b1;
		end
		fill_end = fill_mid;
		if (en && store.push) begin
			if (fill_mid < PTR_W'(BUFFER_DEPTH)) begin
				do_write = 1'b1;
				wr_d     = next_ptr(wr_q);
				fill_end = fill_mid + 1'b1;
			end else begin
				bres.dropped = 1'b1;
			end
		end
		bres.avail = AVAIL_W'(fill_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			wr_q <= wr_d;
			rd_q <= rd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) store_q[slot_of(wr_q)] <= store.push_byte;
	end

endmodule

/* design/hduart_skid.sv */
module hduart_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  hduart_pkg::res_t  res,
	input  logic              out_stall,
	output logic              out_valid,
	output hduart_pkg::res_t  out_res,
	output logic              full
);
	import hduart_pkg::*;

	logic out_valid_q, full_q;
	res_t out_q, skid_q;
	logic take;
	logic load_out, load_skid;

	assign take = out_valid_q && !out_stall;

	always_comb begin
		load_out  = 1'b0;
		load_skid = 1'b0;
		if (!full_q && res_valid) begin
			if (!out_valid_q || take) load_out = 1'b1;
			else load_skid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (full_q) begin
				if (take) full_q <= 1'b0;
			end else if (load_skid) begin
				full_q <= 1'b1;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (take && !full_q) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (full_q && take) out_q <= skid_q;
		else if (load_out) out_q <= res;
		if (load_skid) skid_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign full      = full_q;

endmodule

/* design/half_duplex_uart_with_rx_fifo.sv */
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_stall   rx_level, send_req, send_byte, read_req
// out       result     out_valid / out_stall tx_level, send_accepted, read_byte, read_valid,
//                                            bytes_available, busy_res, rx_dropped
// cfg       write      cfg_we                cfg_index, cfg_data
//
// Each request is one timer tick and passes once through the frame and buffer logic,
// so one request can enter every clock while in_stall is low. A result travels from
// the input stage register through the frame sequencer and ring buffer into the
// output register, where out_valid rises.
// Reset clears all control state, loads the period registers with their defaults
// and leaves the line idle high; no clearing pass is needed.
// A stalled output parks one result in a skid register; in_stall rises only once
// that skid register is occupied and a request waits in the input stage.
`include "assert_macros.svh"

module half_duplex_uart_with_rx_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                rx_level,
	input  logic                                send_req,
	input  logic [7:0]                          send_byte,
	input  logic                                read_req,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                tx_level,
	output logic                                send_accepted,
	output logic [7:0]                          read_byte,
	output logic                                read_valid,
	output logic [hduart_pkg::AVAIL_W-1:0]      bytes_available,
	output logic                                busy_res,
	output logic                                rx_dropped,
	// configuration writes
	input  logic                                cfg_we,
	input  hduart_pkg::reg_idx_t                cfg_index,
	input  logic [hduart_pkg::PERIOD_W-1:0]     cfg_data
);
	import hduart_pkg::*;

	// period registers; a running frame picks up a change at its next timer load
	logic [PERIOD_W-1:0] bit_period_q, start_period_q;

	// input stage
	logic       v_s1;
	logic       rx_level_s1, send_req_s1, read_req_s1;
	logic [7:0] send_byte_s1;

	logic       accept, advance, skid_full;
	frame_res_t fres;
	buf_res_t   bres;
	res_t       res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q   <= BIT_PERIOD_RST;
			start_period_q <= START_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIT_PERIOD:   bit_period_q   <= cfg_data;
				REG_START_PERIOD: start_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the stage request only while the skid register is occupied
	assign advance  = v_s1 && !skid_full;
	assign in_stall = v_s1 && skid_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_level_s1  <= rx_level;
			send_req_s1  <= send_req;
			send_byte_s1 <= send_byte;
			read_req_s1  <= read_req;
		end
	end

	// advance the frame sequencer and bit timer by one tick
	hduart_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.rx_level     (rx_level_s1),
		.send_req     (send_req_s1),
		.send_byte    (send_byte_s1),
		.bit_period   (bit_period_q),
		.start_period (start_period_q),
		.fres         (fres)
	);

	// pop first, then store the received byte or drop it when full
	hduart_rxbuf u_rxbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.read_req (read_req_s1),
		.store    (fres.store),
		.bres     (bres)
	);

	always_comb begin
		res.tx_level        = fres.tx_level;
		res.send_accepted   = fres.accepted;
		res.read_byte       = bres.read_byte;
		res.read_valid      = bres.read_valid;
		res.bytes_available = bres.avail;
		res.busy_res        = fres.busy;
		res.rx_dropped      = bres.dropped;
	end

	hduart_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (advance),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (skid_full)
	);

	assign tx_level        = out_res.tx_level;
	assign send_accepted   = out_res.send_accepted;
	assign read_byte       = out_res.read_byte;
	assign read_valid      = out_res.read_valid;
	assign bytes_available = out_res.bytes_available;
	assign busy_res        = out_res.busy_res;
	assign rx_dropped      = out_res.rx_dropped;

	// a parked result always has a result in front of it
	`ASSERT_IMPLIES(a_skid_behind_out, clk, arst_n, skid_full, out_valid)
	// an empty pop returns zero
	`ASSERT_IMPLIES(a_empty_read_zero, clk, arst_n, out_valid && !read_valid, read_byte == 8'd0)
	// an accepted send starts a frame with the line still idle high
	`ASSERT_IMPLIES(a_send_starts_frame, clk, arst_n, out_valid && send_accepted, busy_res && tx_level)
	// a drop leaves the buffer full and ends the receive frame
	`ASSERT_IMPLIES(a_drop_when_full, clk, arst_n, out_valid && rx_dropped, (bytes_available == AVAIL_W'(BUFFER_DEPTH)) && !busy_res)

endmodule

/* bench/half_duplex_uart_with_rx_fifo_tb.sv */
module half_duplex_uart_with_rx_fifo_tb;
	import hduart_pkg::*;

	// Give up after this many cycles in which no request or result moves.
	localparam int WATCHDOG_LIMIT = 2000;
	// Slack for the pipeline to empty once no result is pending.
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	// Keep the log readable when the block is badly broken.
	localparam int PRINT_CAP = 200;
	localparam int PHASE_REQUESTS = 200;

	// Frame sequencer steps: idle, transmit start..stop, receive sample 1..8.
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_TX_BEGIN = 5'd1;
	localparam logic [4:0] PH_TX_END = 5'd10;
	localparam logic [4:0] PH_RX_BEGIN = 5'd11;
	localparam logic [4:0] PH_RX_END = 5'd18;

	// One timer tick as it travels on the request channel.
	typedef struct packed {
		logic       rx;
		logic       send;
		logic [7:0] data;
		logic       rd;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic rx_level = 1'b1;
	logic send_req = 1'b0;
	logic [7:0] send_byte = 8'h00;
	logic read_req = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic tx_level;
	logic send_accepted;
	logic [7:0] read_byte;
	logic read_valid;
	logic [AVAIL_W-1:0] bytes_available;
	logic busy_res;
	logic rx_dropped;

	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_BIT_PERIOD;
	logic [PERIOD_W-1:0] cfg_data = '0;

	// Predicted UART state, advanced once per accepted request.
	logic [4:0] seq_step;
	logic [PERIOD_W-1:0] tmr_cnt;
	logic [PERIOD_W-1:0] tmr_limit;
	logic [PERIOD_W-1:0] bit_cmp;
	logic [PERIOD_W-1:0] start_cmp;
	logic [7:0] shift_q;
	logic line_q;
	logic rx_last;
	logic [7:0] rx_mem [BUFFER_DEPTH];
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] rd_ptr;

	// Line and buffer status expected for each accepted request, oldest first.
	res_t status_q[$];
	res_t head;

	int sent_cnt = 0;
	int checked_cnt = 0;
	int mismatch_cnt = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	// Set to run a stretch with neither side idling.
	bit no_idle = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	half_duplex_uart_with_rx_fifo u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_level(rx_level),
		.send_req(send_req),
		.send_byte(send_byte),
		.read_req(read_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_level(tx_level),
		.send_accepted(send_accepted),
		.read_byte(read_byte),
		.read_valid(read_valid),
		.bytes_available(bytes_available),
		.busy_res(busy_res),
		.rx_dropped(rx_dropped),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic tick_t mk_tick(logic rx, logic send, logic [7:0] data, logic rd);
		tick_t t;
		t.rx = rx;
		t.send = send;
		t.data = data;
		t.rd = rd;
		return t;
	endfunction

	function automatic logic chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Idle gap before a request or after a result: zero in a third of draws, else random; none in a calm stretch.
	function automatic int draw_wait();
		if (no_idle) return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
	endfunction

	// Ring pointers run modulo twice the depth so that full and empty differ.
	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return PTR_W'((int'(p) + 1) % SPAN);
	endfunction

	function automatic int ring_fill();
		return (int'(wr_ptr) + SPAN - int'(rd_ptr)) % SPAN;
	endfunction

	// Advance the UART by one tick and return the status it shows afterwards.
	function automatic res_t uart_tick(input tick_t t);
		res_t r;
		r = '0;
		// Serve the read first so that a store on the same tick sees the freed slot.
		if (t.rd && ring_fill() != 0) begin
			r.read_byte = rx_mem[int'(rd_ptr) % BUFFER_DEPTH];
			r.read_valid = 1'b1;
			rd_ptr = ptr_inc(rd_ptr);
		end
		if (seq_step == PH_IDLE) begin
			// A send wins over a falling edge on the same tick.
			if (t.send) begin
				shift_q = t.data;
				seq_step = PH_TX_BEGIN;
				tmr_limit = bit_cmp;
				tmr_cnt = '0;
				r.send_accepted = 1'b1;
			end else if (rx_last && !t.rx) begin
				seq_step = PH_RX_BEGIN;
				tmr_limit = start_cmp;
				tmr_cnt = '0;
			end
		end else if (tmr_cnt != tmr_limit) begin
			tmr_cnt = tmr_cnt + 1'b1;
		end else begin
			tmr_cnt = '0;
			if (seq_step == PH_TX_BEGIN) begin
				line_q = 1'b0;
				seq_step = seq_step + 5'd1;
			end else if (seq_step < PH_TX_END) begin
				line_q = shift_q[0];
				shift_q = shift_q >> 1;
				seq_step = seq_step + 5'd1;
			end else if (seq_step == PH_TX_END) begin
				line_q = 1'b1;
				seq_step = PH_IDLE;
			end else begin
				// The first receive sample switches the timer to the bit period.
				if (seq_step == PH_RX_BEGIN) tmr_limit = bit_cmp;
				shift_q = {t.rx, shift_q[7:1]};
				if (seq_step != PH_RX_END) begin
					seq_step = seq_step + 5'd1;
				end else begin
					seq_step = PH_IDLE;
					if (ring_fill() < BUFFER_DEPTH) begin
						rx_mem[int'(wr_ptr) % BUFFER_DEPTH] = shift_q;
						wr_ptr = ptr_inc(wr_ptr);
					end else begin
						r.rx_dropped = 1'b1;
					end
				end
			end
		end
		rx_last = t.rx;
		r.tx_level = line_q;
		r.bytes_available = AVAIL_W'(ring_fill());
		r.busy_res = (seq_step != PH_IDLE);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP)
			$display("result %0d: %s is %0d, expected %0d", checked_cnt, field, got, want);
	endtask

	// Send one tick request: idle a drawn number of cycles, then hold the request
	// until the block takes it. Valid stays high on return so that a following
	// request can go out back to back; whoever pauses next must lower it.
	task automatic push_tick(input tick_t t);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_level <= t.rx;
		send_req <= t.send;
		send_byte <= t.data;
		read_req <= t.rd;
		do @(posedge clk); while (in_stall);
		status_q.push_back(uart_tick(t));
		sent_cnt++;
	endtask

	// Hold off new requests until every pending result is back, then let the
	// pipeline empty out.
	task automatic settle();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PERIOD_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BIT_PERIOD) bit_cmp = value;
		else start_cmp = value;
	endtask

	// Hold the receive line high until any running frame ends; reads and sends
	// ride along, and every send here meets a busy block.
	task automatic run_to_idle(input int rd_pct, input int send_pct);
		while (seq_step != PH_IDLE)
			push_tick(mk_tick(1'b1, chance(send_pct), 8'($urandom), chance(rd_pct)));
	endtask

	// Drive one 8N1 frame onto the receive line, bit_ticks ticks per bit.
	task automatic play_rx_frame(input logic [7:0] data, input int bit_ticks, input int rd_pct);
		logic lvl;
		run_to_idle(rd_pct, 3);
		push_tick(mk_tick(1'b1, 1'b0, 8'($urandom), chance(rd_pct)));
		for (int b = -1; b < 9; b++) begin
			if (b < 0) lvl = 1'b0;
			else if (b > 7) lvl = 1'b1;
			else lvl = data[b];
			repeat (bit_ticks)
				push_tick(mk_tick(lvl, chance(3), 8'($urandom), chance(rd_pct)));
		end
	endtask

	// Reset periods are far too long to finish a frame; just read the empty buffer.
	task automatic test_reset_defaults();
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b1));
		push_tick(mk_tick(1'b1, 1'b0, 8'hFF, 1'b0));
	endtask

	// Zero periods make the timer fire on every tick, so whole frames stay short.
	task automatic test_zero_period();
		logic [7:0] pattern;
		write_reg(REG_BIT_PERIOD, 16'h0000);
		write_reg(REG_START_PERIOD, 16'h0000);
		push_tick(mk_tick(1'b1, 1'b1, 8'hA5, 1'b0));
		// Refused sends and ignored edges throughout; the tick that ends the
		// frame also carries a send, which must not start a new one.
		for (int i = 0; seq_step != PH_IDLE; i++)
			push_tick(mk_tick(i[0], 1'b1, 8'h00, i == 3));
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
		// Send and falling edge together: the send wins.
		push_tick(mk_tick(1'b0, 1'b1, 8'hFF, 1'b0));
		run_to_idle(0, 0);
		// Receive 0x81, then 0x00 with a read on the storing tick.
		pattern = 8'h81;
		push_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
		for (int i = 0; i < 8; i++)
			push_tick(mk_tick(pattern[i], i == 2, 8'h3C, 1'b0));
		pattern = 8'h00;
		push_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
		for (int i = 0; i < 8; i++)
			push_tick(mk_tick(pattern[i], 1'b0, 8'h00, i == 7));
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b1));
		// Buffer is empty again: this read returns nothing.
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b1));
	endtask

	// Period writes during a frame only apply at the next load of the timer.
	task automatic test_mid_frame_period();
		write_reg(REG_BIT_PERIOD, 16'h0000);
		write_reg(REG_START_PERIOD, 16'h0002);
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
		push_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
		push_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
		// Taken up by the receiver at its first sample.
		write_reg(REG_BIT_PERIOD, 16'h0001);
		while (seq_step != PH_IDLE)
			push_tick(mk_tick(1'($urandom), 1'b0, 8'h00, 1'b0));
		write_reg(REG_BIT_PERIOD, 16'h0000);
		push_tick(mk_tick(1'b1, 1'b1, 8'h3C, 1'b0));
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
		// A running transmit never reloads, so this waits for the next frame.
		write_reg(REG_BIT_PERIOD, 16'h0003);
		run_to_idle(0, 0);
	endtask

	// Let the timer count through one long start period, then finish on short bits.
	task automatic test_timer_limit();
		write_reg(REG_BIT_PERIOD, 16'h0040);
		write_reg(REG_START_PERIOD, 16'h0040);
		push_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
		push_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
		write_reg(REG_BIT_PERIOD, 16'h0001);
		no_idle = 1'b1;
		while (seq_step != PH_IDLE)
			push_tick(mk_tick(1'($urandom), chance(1), 8'($urandom), chance(1)));
		no_idle = 1'b0;
	endtask

	// Mostly well-formed receive frames and transmits with random content,
	// plus noise and frames whose bit length does not match the receiver.
	task automatic test_random_traffic();
		int bp;
		int sp;
		int rd_pct;
		int goal;
		int kind;
		int bit_ticks;
		for (int p = 0; p < 6; p++) begin
			// The first two phases hardly read, so the buffer fills and overflows.
			if (p == 0) begin
				bp = 0;
				sp = 0;
			end else if (p == 1) begin
				bp = 1;
				sp = 1;
			end else begin
				bp = $urandom_range(0, 3);
				sp = bp + bp / 2 + $urandom_range(0, 1);
			end
			write_reg(REG_BIT_PERIOD, PERIOD_W'(bp));
			write_reg(REG_START_PERIOD, PERIOD_W'(sp));
			if (p < 2) rd_pct = 1;
			else if (p == 5) rd_pct = 60;
			else rd_pct = $urandom_range(5, 40);
			goal = sent_cnt + PHASE_REQUESTS;
			while (sent_cnt < goal) begin
				no_idle = ($urandom_range(0, 3) == 0);
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					if ($urandom_range(0, 5) == 0) bit_ticks = $urandom_range(1, bp + 2);
					else bit_ticks = bp + 1;
					play_rx_frame(8'($urandom), bit_ticks, rd_pct);
				end else if (kind < 8) begin
					run_to_idle(rd_pct, 0);
					push_tick(mk_tick(1'b1, 1'b1, 8'($urandom), chance(rd_pct)));
					run_to_idle(rd_pct, 5);
				end else begin
					repeat ($urandom_range(1, 10))
						push_tick(mk_tick(1'($urandom), chance(20), 8'($urandom), chance(30)));
				end
			end
			no_idle = 1'b0;
		end
	endtask

	// Result side: compare each accepted result with the oldest prediction, then
	// draw how long to stall before taking the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					head = status_q.pop_front();
					if (tx_level !== head.tx_level)
						report_mismatch("tx_level", tx_level, head.tx_level);
					if (send_accepted !== head.send_accepted)
						report_mismatch("send_accepted", send_accepted, head.send_accepted);
					if (read_byte !== head.read_byte)
						report_mismatch("read_byte", read_byte, head.read_byte);
					if (read_valid !== head.read_valid)
						report_mismatch("read_valid", read_valid, head.read_valid);
					if (bytes_available !== head.bytes_available)
						report_mismatch("bytes_available", bytes_available,
							head.bytes_available);
					if (busy_res !== head.busy_res)
						report_mismatch("busy_res", busy_res, head.busy_res);
					if (rx_dropped !== head.rx_dropped)
						report_mismatch("rx_dropped", rx_dropped, head.rx_dropped);
				end
				checked_cnt++;
				stall_left = draw_wait();
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// Predicted state after reset: line idle high, default periods, empty buffer.
		seq_step = PH_IDLE;
		tmr_cnt = '0;
		bit_cmp = BIT_PERIOD_RST;
		start_cmp = START_PERIOD_RST;
		tmr_limit = BIT_PERIOD_RST;
		shift_q = '0;
		line_q = 1'b1;
		rx_last = 1'b1;
		wr_ptr = '0;
		rd_ptr = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_period();
		test_mid_frame_period();
		test_timer_limit();
		test_random_traffic();

		// Drain everything still in flight, then watch for stray results.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
